// ===== sv/tgd_pkg.sv =====
`timescale 1ns / 1ps

package tgd_pkg;

  // Default knob centre in pixels
  localparam int CENTER_DEF = 120;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Most step results one move may produce
  localparam int MAX_RES = 57;

  // Input commands
  localparam logic [2:0] CMD_PRESS   = 3'd0;
  localparam logic [2:0] CMD_MOVE    = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_CLICK   = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;

  // Gesture codes
  localparam logic [2:0] G_CW   = 3'd0;
  localparam logic [2:0] G_CCW  = 3'd1;
  localparam logic [2:0] G_TAP  = 3'd2;
  localparam logic [2:0] G_SHOW = 3'd3;
  localparam logic [2:0] G_HIDE = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_INNER_RADIUS     = 3'd0;
  localparam logic [2:0] REG_CENTER_RADIUS    = 3'd1;
  localparam logic [2:0] REG_KNOB_STEP        = 3'd2;
  localparam logic [2:0] REG_DEAD_BAND        = 3'd3;
  localparam logic [2:0] REG_DOUBLE_TAP_TICKS = 3'd4;
  localparam logic [2:0] REG_AUTOHIDE_TICKS   = 3'd5;

  // Configuration reset values
  localparam logic [6:0]  RST_INNER_RADIUS     = 7'd32;
  localparam logic [7:0]  RST_CENTER_RADIUS    = 8'd70;
  localparam logic [14:0] RST_KNOB_STEP        = 15'd1800;
  localparam logic [12:0] RST_DEAD_BAND        = 13'd80;
  localparam logic [15:0] RST_DOUBLE_TAP_TICKS = 16'd250;
  localparam logic [15:0] RST_AUTOHIDE_TICKS   = 16'd10000;

  // Operations passed from front to back
  localparam logic [2:0] OP_PRESS   = 3'd0;
  localparam logic [2:0] OP_TURN    = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_CLICK   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam int CROSS_W = 19;
  localparam int SUM_W   = 17;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0] gesture;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  inner_radius;
    logic [7:0]  center_radius;
    logic [14:0] knob_step;
    logic [12:0] dead_band;
    logic [15:0] double_tap_ticks;
    logic [15:0] autohide_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                 op;
    logic                       near;
    logic signed [CROSS_W-1:0]  xprod;
  } op_t;

endpackage

// ===== sv/tgd_queue.sv =====
`timescale 1ns / 1ps

module tgd_queue import tgd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output op_t  pop_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  op_t           mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/tgd_front.sv =====
`timescale 1ns / 1ps

module tgd_front import tgd_pkg::*; #(
  parameter int CENTER = CENTER_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_push,
  input  in_item_t in_data,
  output logic     in_full,
  output logic     q_push,
  output op_t      q_data,
  input  logic     q_full
);

  localparam logic signed [9:0] CTR = 10'(CENTER);

  logic     busy_r, busy_nxt;
  logic     phase_r, phase_nxt;
  logic     engaged_r, engaged_nxt;
  logic [7:0] prev_x_r, prev_x_nxt;
  logic [7:0] prev_y_r, prev_y_nxt;

  in_item_t item_r;
  logic [17:0]        dsq_r;
  logic signed [19:0] pc_r, qc_r;
  logic [13:0]        rsq_r;
  logic [15:0]        csq_r;

  logic               accept;
  logic signed [9:0]  cdx, cdy, pdx, pdy;
  logic signed [19:0] sq_x, sq_y;
  logic signed [20:0] cross_w, db_s;
  logic               on_ring, in_band, near;
  logic               need_push;

  assign in_full = busy_r;
  assign accept  = in_push && !busy_r;

  // Offsets from the centre for current and previous points
  assign cdx  = $signed({2'b00, item_r.pos_x}) - CTR;
  assign cdy  = $signed({2'b00, item_r.pos_y}) - CTR;
  assign pdx  = $signed({2'b00, prev_x_r}) - CTR;
  assign pdy  = $signed({2'b00, prev_y_r}) - CTR;
  assign sq_x = cdx * cdx;
  assign sq_y = cdy * cdy;

  // Classify from the registered products
  assign cross_w = {pc_r[19], pc_r} - {qc_r[19], qc_r};
  assign db_s    = $signed({8'b0, cfg.dead_band});
  assign in_band = (cross_w > -db_s) && (cross_w < db_s);
  assign on_ring = (dsq_r >= {4'b0, rsq_r});
  assign near    = (dsq_r <= {2'b0, csq_r});

  always_comb begin
    busy_nxt    = busy_r;
    phase_nxt   = phase_r;
    engaged_nxt = engaged_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    need_push   = 1'b0;
    q_data.op    = OP_TICK;
    q_data.near  = near;
    q_data.xprod = cross_w[CROSS_W-1:0];

    case (item_r.cmd)
      CMD_PRESS: begin
        need_push = 1'b1;
        q_data.op = OP_PRESS;
      end
      CMD_MOVE: begin
        need_push = engaged_r && on_ring && !in_band;
        q_data.op = OP_TURN;
      end
      CMD_RELEASE: begin
        need_push = 1'b1;
        q_data.op = OP_RELEASE;
      end
      CMD_CLICK: begin
        need_push = 1'b1;
        q_data.op = OP_CLICK;
      end
      CMD_TICK: begin
        need_push = 1'b1;
        q_data.op = OP_TICK;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase

    q_push = 1'b0;
    if (accept) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
    end else if (busy_r && !phase_r) begin
      phase_nxt = 1'b1;
    end else if (busy_r && phase_r && !(need_push && q_full)) begin
      // Finish: hand the request over and update the point history
      q_push   = need_push;
      busy_nxt = 1'b0;
      case (item_r.cmd)
        CMD_PRESS: begin
          prev_x_nxt  = item_r.pos_x;
          prev_y_nxt  = item_r.pos_y;
          engaged_nxt = on_ring;
        end
        CMD_MOVE: begin
          if (engaged_r && on_ring) begin
            prev_x_nxt = item_r.pos_x;
            prev_y_nxt = item_r.pos_y;
          end
        end
        CMD_RELEASE: begin
          engaged_nxt = 1'b0;
        end
        default: begin
          engaged_nxt = engaged_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      phase_r   <= 1'b0;
      engaged_r <= 1'b0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else begin
      busy_r    <= busy_nxt;
      phase_r   <= phase_nxt;
      engaged_r <= engaged_nxt;
      prev_x_r  <= prev_x_nxt;
      prev_y_r  <= prev_y_nxt;
    end
  end

  // Latch the request, then register distance and cross terms
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (busy_r && !phase_r) begin
      dsq_r <= {1'b0, sq_x[16:0]} + {1'b0, sq_y[16:0]};
      pc_r  <= pdx * cdy;
      qc_r  <= pdy * cdx;
      rsq_r <= {7'b0, cfg.inner_radius} * {7'b0, cfg.inner_radius};
      csq_r <= {8'b0, cfg.center_radius} * {8'b0, cfg.center_radius};
    end
  end

endmodule

// ===== sv/tgd_back.sv =====
`timescale 1ns / 1ps

module tgd_back import tgd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  op_t       q_data,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_HIDE2 = 2'd3;

  localparam logic signed [19:0] SAT_HI = 20'sd65535;
  localparam logic signed [19:0] SAT_LO = -20'sd65536;

  logic [1:0]               state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic signed [SUM_W-1:0]  turn_r, turn_nxt;
  logic                     stepped_r, stepped_nxt;
  logic                     suppress_r, suppress_nxt;
  logic                     tap_wait_r, tap_wait_nxt;
  logic [15:0]              tap_cnt_r, tap_cnt_nxt;
  logic                     shown_r, shown_nxt;
  logic [15:0]              idle_cnt_r, idle_cnt_nxt;
  logic [5:0]               n_r, n_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r;

  logic               emit, emit_ok;
  out_item_t          emit_item;
  logic [14:0]        stp;
  logic signed [17:0] stp_s, sum_s, cw_rest, ccw_rest;
  logic               cw_go, ccw_go, room, last_n;
  logic [15:0]        tap_lim, hide_lim;
  logic [16:0]        tap_inc, idle_inc;
  logic               tap_fire, hide_fire;
  logic signed [19:0] wide;
  logic signed [SUM_W-1:0] sat;

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;
  assign emit_ok   = !out_valid_r || out_pop;

  // Step arithmetic on the running sum
  assign stp      = (cfg.knob_step == '0) ? 15'd1 : cfg.knob_step;
  assign stp_s    = $signed({3'b000, stp});
  assign sum_s    = {turn_r[SUM_W-1], turn_r};
  assign cw_go    = sum_s >= stp_s;
  assign ccw_go   = sum_s <= -stp_s;
  assign cw_rest  = sum_s - stp_s;
  assign ccw_rest = sum_s + stp_s;
  assign room     = n_r < 6'(MAX_RES);
  assign last_n   = n_r == 6'(MAX_RES - 1);

  // Saturating add of a new cross product
  assign wide = {{3{turn_r[SUM_W-1]}}, turn_r} + {op_r.xprod[CROSS_W-1], op_r.xprod};
  assign sat  = (wide > SAT_HI) ? SAT_HI[SUM_W-1:0] :
                (wide < SAT_LO) ? SAT_LO[SUM_W-1:0] : wide[SUM_W-1:0];

  // Tick timers
  assign tap_lim   = (cfg.double_tap_ticks == '0) ? 16'd1 : cfg.double_tap_ticks;
  assign hide_lim  = (cfg.autohide_ticks == '0) ? 16'd1 : cfg.autohide_ticks;
  assign tap_inc   = {1'b0, tap_cnt_r} + 17'd1;
  assign idle_inc  = {1'b0, idle_cnt_r} + 17'd1;
  assign tap_fire  = tap_wait_r && (tap_inc >= {1'b0, tap_lim});
  assign hide_fire = shown_r && (idle_inc >= {1'b0, hide_lim});

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    turn_nxt     = turn_r;
    stepped_nxt  = stepped_r;
    suppress_nxt = suppress_r;
    tap_wait_nxt = tap_wait_r;
    tap_cnt_nxt  = tap_cnt_r;
    shown_nxt    = shown_r;
    idle_cnt_nxt = idle_cnt_r;
    n_nxt        = n_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_item.gesture = G_CW;
    emit_item.last    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        // Take the next request from the queue
        if (!q_empty) begin
          q_pop     = 1'b1;
          op_nxt    = q_data;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (op_r.op)
          OP_PRESS: begin
            turn_nxt    = '0;
            stepped_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end
          OP_RELEASE: begin
            if (stepped_r) begin
              suppress_nxt = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
          OP_CLICK: begin
            if (suppress_r) begin
              suppress_nxt = 1'b0;
              state_nxt    = ST_IDLE;
            end else if (tap_wait_r) begin
              if (!shown_r) begin
                if (emit_ok) begin
                  emit              = 1'b1;
                  emit_item.gesture = G_SHOW;
                  tap_wait_nxt      = 1'b0;
                  tap_cnt_nxt       = '0;
                  shown_nxt         = 1'b1;
                  idle_cnt_nxt      = '0;
                  state_nxt         = ST_IDLE;
                end
              end else if (op_r.near) begin
                if (emit_ok) begin
                  emit              = 1'b1;
                  emit_item.gesture = G_HIDE;
                  tap_wait_nxt      = 1'b0;
                  tap_cnt_nxt       = '0;
                  shown_nxt         = 1'b0;
                  state_nxt         = ST_IDLE;
                end
              end else begin
                tap_wait_nxt = 1'b0;
                tap_cnt_nxt  = '0;
                state_nxt    = ST_IDLE;
              end
            end else begin
              tap_wait_nxt = 1'b1;
              tap_cnt_nxt  = '0;
              state_nxt    = ST_IDLE;
            end
          end
          OP_TICK: begin
            if (!((tap_fire || hide_fire) && !emit_ok)) begin
              // Advance the tap wait, then the autohide timer
              if (tap_wait_r) begin
                if (tap_fire) begin
                  tap_wait_nxt = 1'b0;
                  tap_cnt_nxt  = '0;
                end else begin
                  tap_cnt_nxt = tap_inc[15:0];
                end
              end
              if (shown_r) begin
                if (hide_fire) begin
                  idle_cnt_nxt = '0;
                  shown_nxt    = 1'b0;
                  tap_wait_nxt = 1'b0;
                  tap_cnt_nxt  = '0;
                end else begin
                  idle_cnt_nxt = idle_inc[15:0];
                end
              end
              state_nxt = ST_IDLE;
              if (tap_fire) begin
                emit              = 1'b1;
                emit_item.gesture = G_TAP;
                emit_item.last    = !hide_fire;
                if (hide_fire) begin
                  state_nxt = ST_HIDE2;
                end
              end else if (hide_fire) begin
                emit              = 1'b1;
                emit_item.gesture = G_HIDE;
              end
            end
          end
          OP_TURN: begin
            turn_nxt  = sat;
            n_nxt     = '0;
            state_nxt = ST_STEP;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_STEP: begin
        // Emit one whole step per cycle while the output is free, until the sum is used up or MAX_RES steps are out
        if (room && cw_go) begin
          if (emit_ok) begin
            emit              = 1'b1;
            emit_item.gesture = G_CW;
            emit_item.last    = last_n || (cw_rest < stp_s);
            turn_nxt          = cw_rest[SUM_W-1:0];
            stepped_nxt       = 1'b1;
            n_nxt             = n_r + 1'b1;
          end
        end else if (room && ccw_go) begin
          if (emit_ok) begin
            emit              = 1'b1;
            emit_item.gesture = G_CCW;
            emit_item.last    = last_n || (ccw_rest > -stp_s);
            turn_nxt          = ccw_rest[SUM_W-1:0];
            stepped_nxt       = 1'b1;
            n_nxt             = n_r + 1'b1;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_HIDE2: begin
        if (emit_ok) begin
          emit              = 1'b1;
          emit_item.gesture = G_HIDE;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Hold the result until popped
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      turn_r      <= '0;
      stepped_r   <= 1'b0;
      suppress_r  <= 1'b0;
      tap_wait_r  <= 1'b0;
      tap_cnt_r   <= '0;
      shown_r     <= 1'b0;
      idle_cnt_r  <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      turn_r      <= turn_nxt;
      stepped_r   <= stepped_nxt;
      suppress_r  <= suppress_nxt;
      tap_wait_r  <= tap_wait_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      shown_r     <= shown_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (emit) begin
      out_data_r <= emit_item;
    end
  end

endmodule

// ===== sv/touch_ring_gesture_decoder.sv =====
`timescale 1ns / 1ps

// Touch ring gesture decoder.
// Input: queue-style push/full channel carrying cmd, pos_x, pos_y; a request
// is taken when push is high and full is low. Results: queue-style
// empty/pop channel carrying gesture and last; last marks the final result
// of one input request, and requests that cause nothing produce no result.
// Configuration: cfg_valid/cfg_ready write port (always ready) with a
// register index and data; write only while the block is idle.
// Flow: the front handles one request at a time (capture, multiply, classify)
// and accepts the next only after classify; classify waits while its op must go into a full queue.
// The back runs one request from the queue at a time: the idle state pops it,
// the exec state carries it out, and for a knob turn the step state then emits
// one step result at a time (up to 57 steps) until the sum is used up.
// A stalled receiver stops the back at its output register; the front keeps
// filling the queue until it is full, then raises full.
// Reset (synchronous, rst_n low): configuration returns to defaults, the ring
// is hidden, all timers, queue and output register are cleared.
module touch_ring_gesture_decoder import tgd_pkg::*; #(
  parameter int CENTER      = CENTER_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_data,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_empty;
  op_t  q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Update the addressed configuration register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_INNER_RADIUS:     cfg_nxt.inner_radius     = cfg_data[6:0];
        REG_CENTER_RADIUS:    cfg_nxt.center_radius    = cfg_data[7:0];
        REG_KNOB_STEP:        cfg_nxt.knob_step        = cfg_data[14:0];
        REG_DEAD_BAND:        cfg_nxt.dead_band        = cfg_data[12:0];
        REG_DOUBLE_TAP_TICKS: cfg_nxt.double_tap_ticks = cfg_data;
        REG_AUTOHIDE_TICKS:   cfg_nxt.autohide_ticks   = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inner_radius     <= RST_INNER_RADIUS;
      cfg_r.center_radius    <= RST_CENTER_RADIUS;
      cfg_r.knob_step        <= RST_KNOB_STEP;
      cfg_r.dead_band        <= RST_DEAD_BAND;
      cfg_r.double_tap_ticks <= RST_DOUBLE_TAP_TICKS;
      cfg_r.autohide_ticks   <= RST_AUTOHIDE_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tgd_front #(
    .CENTER (CENTER)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  tgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  tgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // Front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("request pushed into full queue");

  // Back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("request popped from empty queue");

  // An accepted input blocks the channel while it is classified
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("front accepted without going busy");
`endif

endmodule

// ===== tb/touch_ring_gesture_decoder_test.sv =====
`timescale 1ns / 1ps

module touch_ring_gesture_decoder_test;
  import tgd_pkg::*;

  localparam int  HALF_PERIOD      = 6;
  localparam int  RING_CENTER      = CENTER_DEF;
  localparam int  SETTLE_CYCLES    = 40;
  localparam int  RANDOM_PER_PHASE = 92;
  localparam int  REPORT_LIMIT     = 10;
  localparam int  SUM_HIGH         = 65535;
  localparam int  SUM_LOW          = -65536;
  localparam real DEG              = 3.14159265358979 / 180.0;
  localparam real TIMEOUT_NS       = 6000000.0;

  // Expected gestures: mirror of the decoder state and registers
  class gesture_scoreboard;
    logic [6:0]  inner_radius;
    logic [7:0]  center_radius;
    logic [14:0] knob_step;
    logic [12:0] dead_band;
    logic [15:0] double_tap_ticks;
    logic [15:0] autohide_ticks;
    logic [7:0]  prev_x;
    logic [7:0]  prev_y;
    int          turn_sum;
    bit          knob_engaged;
    bit          knob_stepped;
    bit          click_suppress;
    bit          tap_waiting;
    bit          ring_shown;
    int          tap_count;
    int          idle_count;
    logic [2:0]  batch[$];
    out_item_t   gesture_q[$];
    int          errors;
    int          results_seen;
    int          gesture_seen[5];

    function new();
      inner_radius     = RST_INNER_RADIUS;
      center_radius    = RST_CENTER_RADIUS;
      knob_step        = RST_KNOB_STEP;
      dead_band        = RST_DEAD_BAND;
      double_tap_ticks = RST_DOUBLE_TAP_TICKS;
      autohide_ticks   = RST_AUTOHIDE_TICKS;
      prev_x           = '0;
      prev_y           = '0;
      turn_sum         = 0;
      tap_count        = 0;
      idle_count       = 0;
      errors           = 0;
      results_seen     = 0;
      foreach (gesture_seen[i]) gesture_seen[i] = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [15:0] value);
      case (index)
        REG_INNER_RADIUS:     inner_radius     = value[6:0];
        REG_CENTER_RADIUS:    center_radius    = value[7:0];
        REG_KNOB_STEP:        knob_step        = value[14:0];
        REG_DEAD_BAND:        dead_band        = value[12:0];
        REG_DOUBLE_TAP_TICKS: double_tap_ticks = value;
        REG_AUTOHIDE_TICKS:   autohide_ticks   = value;
        default: ;
      endcase
    endfunction

    function int dist_sq(logic [7:0] x, logic [7:0] y);
      int dx;
      int dy;
      dx = int'(x) - RING_CENTER;
      dy = int'(y) - RING_CENTER;
      return dx * dx + dy * dy;
    endfunction

    function void hide_ring();
      ring_shown  = 1'b0;
      tap_waiting = 1'b0;
      tap_count   = 0;
    endfunction

    // Accumulate the cross product about the centre and emit whole steps
    function void turn_knob(logic [7:0] x, logic [7:0] y);
      int r;
      int px;
      int py;
      int cx;
      int cy;
      int xprod;
      int db;
      int sum;
      int stride;
      r = int'(inner_radius);
      if (dist_sq(x, y) < r * r) return;
      px = int'(prev_x) - RING_CENTER;
      py = int'(prev_y) - RING_CENTER;
      cx = int'(x) - RING_CENTER;
      cy = int'(y) - RING_CENTER;
      xprod = px * cy - py * cx;
      db = int'(dead_band);
      prev_x = x;
      prev_y = y;
      if (xprod > -db && xprod < db) return;
      sum = turn_sum + xprod;
      if (sum > SUM_HIGH) sum = SUM_HIGH;
      if (sum < SUM_LOW) sum = SUM_LOW;
      stride = (knob_step == 0) ? 1 : int'(knob_step);
      while (sum >= stride && batch.size() < MAX_RES) begin
        batch.push_back(G_CW);
        sum -= stride;
        knob_stepped = 1'b1;
      end
      while (sum <= -stride && batch.size() < MAX_RES) begin
        batch.push_back(G_CCW);
        sum += stride;
        knob_stepped = 1'b1;
      end
      turn_sum = sum;
    endfunction

    // Advance the mirror by one accepted request and queue its gestures
    function void note_request(in_item_t req);
      int        r;
      int        c;
      int        lim;
      out_item_t g;
      batch.delete();
      r = int'(inner_radius);
      c = int'(center_radius);
      case (req.cmd)
        CMD_PRESS: begin
          prev_x       = req.pos_x;
          prev_y       = req.pos_y;
          turn_sum     = 0;
          knob_stepped = 1'b0;
          knob_engaged = dist_sq(req.pos_x, req.pos_y) >= r * r;
        end
        CMD_MOVE: begin
          if (knob_engaged) turn_knob(req.pos_x, req.pos_y);
        end
        CMD_RELEASE: begin
          if (knob_stepped) click_suppress = 1'b1;
          knob_engaged = 1'b0;
        end
        CMD_CLICK: begin
          if (click_suppress) begin
            click_suppress = 1'b0;
          end else if (tap_waiting) begin
            tap_waiting = 1'b0;
            tap_count   = 0;
            if (!ring_shown) begin
              ring_shown = 1'b1;
              idle_count = 0;
              batch.push_back(G_SHOW);
            end else if (dist_sq(req.pos_x, req.pos_y) <= c * c) begin
              hide_ring();
              batch.push_back(G_HIDE);
            end
          end else begin
            tap_waiting = 1'b1;
            tap_count   = 0;
          end
        end
        CMD_TICK: begin
          if (tap_waiting) begin
            lim = (double_tap_ticks == 0) ? 1 : int'(double_tap_ticks);
            tap_count++;
            if (tap_count >= lim) begin
              tap_waiting = 1'b0;
              tap_count   = 0;
              batch.push_back(G_TAP);
            end
          end
          if (ring_shown) begin
            lim = (autohide_ticks == 0) ? 1 : int'(autohide_ticks);
            idle_count++;
            if (idle_count >= lim) begin
              idle_count = 0;
              hide_ring();
              batch.push_back(G_HIDE);
            end
          end
        end
        default: ;
      endcase
      foreach (batch[i]) begin
        g.gesture = batch[i];
        g.last    = (i == batch.size() - 1);
        gesture_q.push_back(g);
      end
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s: expected gesture %0d last %0d, got gesture %0d last %0d",
                 $time, what, want.gesture, want.last, got.gesture, got.last);
    endfunction

    // Compare one popped gesture against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (got.gesture <= G_HIDE) gesture_seen[got.gesture]++;
      if (gesture_q.size() == 0) begin
        want = '0;
        report("gesture with none expected", want, got);
      end else begin
        want = gesture_q.pop_front();
        if (got.gesture !== want.gesture || got.last !== want.last)
          report("gesture mismatch", want, got);
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  in_item_t    in_data   = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop   = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  gesture_scoreboard board;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int requests_sent   = 0;
  int reg_writes      = 0;
  int settings_used   = 0;

  touch_ring_gesture_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every popped gesture
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_result(out_data);
  end

  // Offer one request after a random gap and hold it until taken
  task automatic push_request(logic [2:0] cmd, logic [7:0] x, logic [7:0] y);
    in_item_t req;
    int       gap;
    req.cmd   = cmd;
    req.pos_x = x;
    req.pos_y = y;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 30) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_full);
    board.note_request(req);
    if (cmd <= CMD_TICK) requests_sent++;
  endtask

  // Hold the sender until every expected gesture has come and the block is quiet
  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (board.gesture_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(index, value);
    reg_writes++;
  endtask

  task automatic apply_settings(int min_radius, int hub_radius, int step, int band,
                                int tap_ticks, int hide_ticks);
    write_reg(REG_INNER_RADIUS, min_radius);
    write_reg(REG_CENTER_RADIUS, hub_radius);
    write_reg(REG_KNOB_STEP, step);
    write_reg(REG_DEAD_BAND, band);
    write_reg(REG_DOUBLE_TAP_TICKS, tap_ticks);
    write_reg(REG_AUTOHIDE_TICKS, hide_ticks);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic ring_point(input real radius, input real angle,
                            output logic [7:0] x, output logic [7:0] y);
    int px;
    int py;
    px = RING_CENTER + $rtoi(radius * $cos(angle));
    py = RING_CENTER + $rtoi(radius * $sin(angle));
    x = (px < 0) ? 8'd0 : (px > 255) ? 8'd255 : px[7:0];
    y = (py < 0) ? 8'd0 : (py > 255) ? 8'd255 : py[7:0];
  endtask

  // Press, drag around the ring, usually release, sometimes click after
  task automatic knob_turn();
    real        radius;
    real        angle;
    real        stride;
    logic [7:0] x;
    logic [7:0] y;
    int         moves;
    radius = $urandom_range(8, 125);
    angle  = $urandom_range(0, 359) * DEG;
    stride = $urandom_range(2, ($urandom_range(4) == 0) ? 170 : 45) * DEG;
    if ($urandom_range(1)) stride = -stride;
    ring_point(radius, angle, x, y);
    push_request(CMD_PRESS, x, y);
    moves = $urandom_range(1, 10);
    repeat (moves) begin
      case ($urandom_range(9))
        0: push_request(CMD_MOVE, x, y);
        1: push_request(CMD_MOVE, RING_CENTER - 6 + $urandom_range(12),
                        RING_CENTER - 6 + $urandom_range(12));
        default: begin
          angle  = angle + stride;
          radius = radius + $urandom_range(6) - 3.0;
          ring_point(radius, angle, x, y);
          push_request(CMD_MOVE, x, y);
        end
      endcase
    end
    if ($urandom_range(9) != 0) push_request(CMD_RELEASE, $urandom, $urandom);
    if ($urandom_range(1)) push_request(CMD_CLICK, x, y);
  endtask

  // One click, a few ticks, often a second click near or far from the hub
  task automatic click_pair();
    int waits;
    int span;
    span = (board.double_tap_ticks < 8) ? int'(board.double_tap_ticks) + 1 : 8;
    push_request(CMD_CLICK, $urandom_range(239), $urandom_range(239));
    waits = $urandom_range(0, span);
    repeat (waits) push_request(CMD_TICK, $urandom, $urandom);
    if ($urandom_range(9) < 6) begin
      if ($urandom_range(1))
        push_request(CMD_CLICK, RING_CENTER - 50 + $urandom_range(100),
                     RING_CENTER - 50 + $urandom_range(100));
      else
        push_request(CMD_CLICK, $urandom_range(239), $urandom_range(239));
    end
  endtask

  task automatic tick_burst();
    int count;
    count = $urandom_range(1, (board.autohide_ticks < 40) ?
                              int'(board.autohide_ticks) + 1 : 40);
    repeat (count) push_request(CMD_TICK, $urandom, $urandom);
  endtask

  task automatic random_phase(int count);
    int  first;
    bit  paused;
    first  = requests_sent;
    paused = 1'b0;
    while (requests_sent - first < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: knob_turn();
        5, 6, 7:       click_pair();
        8:             tick_burst();
        default:       push_request($urandom_range(7), $urandom, $urandom);
      endcase
      if (!paused && requests_sent - first >= count / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("touch_ring_gesture_decoder_test: errors");
    $finish;
  end

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: unknown commands, a turn with off-ring and jitter moves,
    // swallowed click after the turn, then a double click showing the ring
    push_request(3'd5, 8'hFF, 8'h00);
    push_request(3'd6, 8'h00, 8'hFF);
    push_request(3'd7, 8'hFF, 8'hFF);
    push_request(CMD_PRESS, 8'd0, 8'd0);
    push_request(CMD_MOVE, 8'd239, 8'd0);
    push_request(CMD_MOVE, 8'd120, 8'd120);
    push_request(CMD_MOVE, 8'd239, 8'd0);
    push_request(CMD_MOVE, 8'd255, 8'd255);
    push_request(CMD_RELEASE, 8'd0, 8'd0);
    push_request(CMD_CLICK, 8'd239, 8'd239);
    push_request(CMD_CLICK, 8'd120, 8'd120);
    push_request(CMD_CLICK, 8'd120, 8'd120);

    // Zero step and zero tick limits: capped step bursts both ways,
    // tap and hide on one tick, show then hide at the hub
    drain_results();
    apply_settings(127, 255, 0, 0, 0, 0);
    push_request(CMD_PRESS, 8'd0, 8'd0);
    push_request(CMD_MOVE, 8'd239, 8'd0);
    push_request(CMD_MOVE, 8'd239, 8'd239);
    push_request(CMD_PRESS, 8'd0, 8'd0);
    push_request(CMD_MOVE, 8'd0, 8'd239);
    push_request(CMD_MOVE, 8'd0, 8'd239);
    push_request(CMD_RELEASE, 8'd0, 8'd0);
    push_request(CMD_CLICK, 8'd10, 8'd10);
    push_request(CMD_CLICK, 8'd10, 8'd10);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_CLICK, 8'd200, 8'd30);
    push_request(CMD_CLICK, 8'd200, 8'd30);
    push_request(CMD_CLICK, 8'd120, 8'd120);
    push_request(CMD_CLICK, 8'd120, 8'd120);

    // Random traffic: no idling, low extremes
    drain_results();
    apply_settings(0, 170, 512, 0, 1, 1);
    random_phase(RANDOM_PER_PHASE);

    // Sender idles, high extremes
    drain_results();
    sender_idle_pct = 49;
    apply_settings(120, 0, 16384, 4096, $urandom_range(2, 6), 65535);
    random_phase(RANDOM_PER_PHASE);

    // Receiver stalls, mid-range settings
    drain_results();
    sender_idle_pct = 0;
    recv_stall_pct  = 49;
    apply_settings($urandom_range(100), $urandom_range(170), $urandom_range(512, 2500),
                   $urandom_range(300), $urandom_range(1, 6), $urandom_range(5, 40));
    random_phase(RANDOM_PER_PHASE);

    // Both sides idle
    drain_results();
    sender_idle_pct = 14;
    recv_stall_pct  = 14;
    apply_settings($urandom_range(100), $urandom_range(170), $urandom_range(512, 4000),
                   $urandom_range(600), 65535, $urandom_range(5, 40));
    random_phase(RANDOM_PER_PHASE);

    drain_results();
    $display("Run covered %0d touch requests under %0d settings (%0d register writes).",
             requests_sent, settings_used, reg_writes);
    $display("Gestures checked: %0d (cw %0d, ccw %0d, tap %0d, show %0d, hide %0d).",
             board.results_seen, board.gesture_seen[0], board.gesture_seen[1],
             board.gesture_seen[2], board.gesture_seen[3], board.gesture_seen[4]);
    if (board.errors == 0 && board.gesture_q.size() == 0) begin
      $display("touch_ring_gesture_decoder_test: clean");
    end else begin
      $display("touch_ring_gesture_decoder_test: errors");
    end
    $finish;
  end

endmodule
